@@ sv/mpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, constants and helpers of the multidrop poll collector.
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

   localparam int MAX_SLAVES     = 16;
   localparam int SLAVE_ID_LIMIT = 16;
   localparam int FRAME_BYTES    = 6;
   localparam int MAX_RESULTS    = 3;

   // Slave count cap: MAX_SLAVES, but never past what a 4-bit slave id can address.
   localparam logic [4:0] SLAVE_CAP =
      5'((MAX_SLAVES < SLAVE_ID_LIMIT) ? MAX_SLAVES : SLAVE_ID_LIMIT);
   localparam logic [7:0]  FRAME_LEN = 8'(FRAME_BYTES);
   localparam logic [16:0] TICK_MAX  = 17'h1FFFF;

   // Event codes on the request channel; code 3 has no meaning
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_FRAME = 2'd2;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_START_MARKER    = 3'd0;
   localparam logic [2:0] CSR_REQUEST_COMMAND = 3'd1;
   localparam logic [2:0] CSR_DONE_COMMAND    = 3'd2;
   localparam logic [2:0] CSR_FINAL_STATUS    = 3'd3;
   localparam logic [2:0] CSR_CONTINUE_STATUS = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT_TICKS   = 3'd5;
   localparam logic [2:0] CSR_SLAVE_TOTAL     = 3'd6;

   typedef enum logic [1:0] {
      KIND_REQUEST  = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_RECORD   = 2'd2,
      KIND_FINISHED = 2'd3
   } mpc_kind_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] frame_length;
      logic [7:0] frame_start;
      logic [7:0] frame_slave;
      logic [7:0] frame_session;
      logic [7:0] frame_count_low;
      logic [7:0] frame_count_high;
      logic [7:0] frame_status;
   } mpc_item_type;

   typedef struct packed {
      mpc_kind_type result_kind;
      logic [3:0]   slave_id;
      logic [7:0]   command_byte;
      logic [7:0]   session;
      logic [15:0]  counter;
      logic         last;
   } mpc_result_type;

   typedef struct packed {
      mpc_result_type [MAX_RESULTS-1:0] entry;
      logic [1:0]                       count;
   } mpc_bundle_type;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [7:0]  request_command;
      logic [7:0]  done_command;
      logic [7:0]  final_status_code;
      logic [7:0]  continue_status_code;
      logic [15:0] timeout_ticks;
      logic [4:0]  slave_total;
   } mpc_cfg_type;

   function automatic mpc_result_type make_result(input mpc_kind_type kind,
                                                  input logic [3:0]   sid,
                                                  input logic [7:0]   cmd,
                                                  input logic [7:0]   ses,
                                                  input logic [15:0]  cnt);
      mpc_result_type r;
      r.result_kind  = kind;
      r.slave_id     = sid;
      r.command_byte = cmd;
      r.session      = ses;
      r.counter      = cnt;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/mpc_req_if.sv @@
// ----------------------------------------------------------------------------
// mpc_req_if
// Event channel into the poll collector: valid/ready plus the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] frame_length;
   logic [7:0] frame_start;
   logic [7:0] frame_slave;
   logic [7:0] frame_session;
   logic [7:0] frame_count_low;
   logic [7:0] frame_count_high;
   logic [7:0] frame_status;

   modport source (output valid, output func, output frame_length, output frame_start,
                   output frame_slave, output frame_session, output frame_count_low,
                   output frame_count_high, output frame_status, input ready);
   modport sink   (input valid, input func, input frame_length, input frame_start,
                   input frame_slave, input frame_session, input frame_count_low,
                   input frame_count_high, input frame_status, output ready);
endinterface

`default_nettype wire

@@ sv/mpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mpc_rsp_if
// Result channel out of the poll collector: valid/ready plus result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [3:0]  slave_id;
   logic [7:0]  command_byte;
   logic [7:0]  session;
   logic [15:0] counter;
   logic        last;

   modport source (output valid, output result_kind, output slave_id, output command_byte,
                   output session, output counter, output last, input ready);
   modport sink   (input valid, input result_kind, input slave_id, input command_byte,
                   input session, input counter, input last, output ready);
endinterface

`default_nettype wire

@@ sv/multidrop_poll_collector_unit.sv @@
// ----------------------------------------------------------------------------
// multidrop_poll_collector_unit
// Poll master for a multidrop bus: turns start, tick and frame events into
// request frames, done frames, data records and a collection-finished mark.
//
// req_chan carries one event per item (start, millisecond tick, or a parsed
// received frame). rsp_chan carries results, one per item, with last set on
// the final result an event causes; an event causes zero to three results.
// The csr_ port writes the seven configuration registers; the user must write
// them only while no item is in flight, the block itself does not enforce it.
// The first result of an event passes the input register, the result bundle
// register and the output register before it is valid.
// Throughput: one event per cycle while rsp_chan does not stall, when each
// causes at most one result; an event with more results holds the result
// sequencer until all have left the one-result-per-cycle output port.
// Reset clears the polling state to idle and loads the register defaults.
// A stalled rsp_chan holds its result; the sequencer and input register fill
// and req_chan.ready then drops until results drain.
// ----------------------------------------------------------------------------
`default_nettype none

module multidrop_poll_collector_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   mpc_req_if.sink          req_chan,
   mpc_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import mpc_pkg::*;

   mpc_cfg_type    cfg_ff;
   logic           a_valid_ff;
   mpc_item_type   a_item_ff;
   mpc_item_type   req_item;
   mpc_bundle_type bundle;
   logic           seq_free;
   logic           advance;
   logic           req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker         <= 8'd170;
         cfg_ff.request_command      <= 8'd1;
         cfg_ff.done_command         <= 8'd2;
         cfg_ff.final_status_code    <= 8'd0;
         cfg_ff.continue_status_code <= 8'd1;
         cfg_ff.timeout_ticks        <= 16'd100;
         cfg_ff.slave_total          <= 5'd16;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_MARKER:    cfg_ff.start_marker         <= csr_write_data[7:0];
            CSR_REQUEST_COMMAND: cfg_ff.request_command      <= csr_write_data[7:0];
            CSR_DONE_COMMAND:    cfg_ff.done_command         <= csr_write_data[7:0];
            CSR_FINAL_STATUS:    cfg_ff.final_status_code    <= csr_write_data[7:0];
            CSR_CONTINUE_STATUS: cfg_ff.continue_status_code <= csr_write_data[7:0];
            CSR_TIMEOUT_TICKS:   cfg_ff.timeout_ticks        <= csr_write_data;
            CSR_SLAVE_TOTAL:     cfg_ff.slave_total          <= csr_write_data[4:0];
            default: begin
            end
         endcase
      end
   end

   assign req_item.func             = req_chan.func;
   assign req_item.frame_length     = req_chan.frame_length;
   assign req_item.frame_start      = req_chan.frame_start;
   assign req_item.frame_slave      = req_chan.frame_slave;
   assign req_item.frame_session    = req_chan.frame_session;
   assign req_item.frame_count_low  = req_chan.frame_count_low;
   assign req_item.frame_count_high = req_chan.frame_count_high;
   assign req_item.frame_status     = req_chan.frame_status;

   // the input register steps once the sequencer can take its bundle
   assign advance        = a_valid_ff && seq_free;
   assign req_chan.ready = !a_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_take) begin
         a_valid_ff <= 1'b1;
      end else if (advance) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_item_ff <= req_item;
      end
   end

   mpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (a_item_ff),
      .cfg    (cfg_ff),
      .bundle (bundle)
   );

   mpc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && (bundle.count != 2'd0)),
      .bundle   (bundle),
      .free     (seq_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ sv/mpc_core.sv @@
// ----------------------------------------------------------------------------
// mpc_core
// Polling state and the single-pass event step: updates the state and builds
// the bundle of up to three results for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire mpc_pkg::mpc_item_type  item,
   input  wire mpc_pkg::mpc_cfg_type   cfg,
   output mpc_pkg::mpc_bundle_type     bundle
);
   import mpc_pkg::*;

   logic        active_ff,    active_in;
   logic        listening_ff, listening_in;
   logic        got_data_ff,  got_data_in;
   logic [3:0]  slave_index_ff, slave_index_in;
   logic [16:0] tick_count_ff,  tick_count_in;

   logic [4:0]  eff_total;
   logic [4:0]  idx_inc;
   logic [16:0] tick_inc;
   logic        frame_match;

   always_comb begin
      if (cfg.slave_total == 5'd0) begin
         eff_total = 5'd1;
      end else if (cfg.slave_total > SLAVE_CAP) begin
         eff_total = SLAVE_CAP;
      end else begin
         eff_total = cfg.slave_total;
      end
   end

   assign idx_inc  = {1'b0, slave_index_ff} + 5'd1;
   assign tick_inc = (tick_count_ff != TICK_MAX) ? tick_count_ff + 17'd1 : tick_count_ff;
   assign frame_match = active_ff && listening_ff && (item.frame_length == FRAME_LEN) &&
                        (item.frame_start == cfg.start_marker) &&
                        (item.frame_slave == {4'd0, slave_index_ff});

   always_comb begin
      logic       end_slave;
      logic       end_got;
      logic [1:0] n;
      active_in      = active_ff;
      listening_in   = listening_ff;
      got_data_in    = got_data_ff;
      slave_index_in = slave_index_ff;
      tick_count_in  = tick_count_ff;
      bundle         = '0;
      end_slave      = 1'b0;
      end_got        = got_data_ff;
      n              = 2'd0;

      unique case (item.func)
         FUNC_START: begin
            active_in      = 1'b1;
            listening_in   = 1'b1;
            got_data_in    = 1'b0;
            slave_index_in = 4'd0;
            tick_count_in  = 17'd0;
            bundle.entry[0] = make_result(KIND_REQUEST, 4'd0, cfg.request_command,
                                          8'd0, 16'd0);
            n = 2'd1;
         end
         FUNC_TICK: begin
            if (active_ff) begin
               tick_count_in = tick_inc;
               end_slave     = (tick_inc > {1'b0, cfg.timeout_ticks});
            end
         end
         FUNC_FRAME: begin
            if (frame_match) begin
               got_data_in = 1'b1;
               bundle.entry[0] = make_result(KIND_RECORD, slave_index_ff, 8'd0,
                                             item.frame_session,
                                             {item.frame_count_high, item.frame_count_low});
               n = 2'd1;
               // final wins over continue when both codes are equal
               if (item.frame_status == cfg.final_status_code) begin
                  end_slave = 1'b1;
                  end_got   = 1'b1;
               end else if (item.frame_status != cfg.continue_status_code) begin
                  listening_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      if (end_slave) begin
         if (end_got) begin
            bundle.entry[n] = make_result(KIND_DONE, slave_index_ff, cfg.done_command,
                                          8'd0, 16'd0);
            n = n + 2'd1;
         end
         if (idx_inc >= eff_total) begin
            active_in     = 1'b0;
            listening_in  = 1'b0;
            got_data_in   = 1'b0;
            tick_count_in = 17'd0;
            bundle.entry[n] = make_result(KIND_FINISHED, 4'd0, 8'd0, 8'd0, 16'd0);
         end else begin
            slave_index_in = idx_inc[3:0];
            tick_count_in  = 17'd0;
            got_data_in    = 1'b0;
            listening_in   = 1'b1;
            bundle.entry[n] = make_result(KIND_REQUEST, idx_inc[3:0], cfg.request_command,
                                          8'd0, 16'd0);
         end
         n = n + 2'd1;
      end

      if (n != 2'd0) begin
         bundle.entry[n - 2'd1].last = 1'b1;
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         listening_ff   <= 1'b0;
         got_data_ff    <= 1'b0;
         slave_index_ff <= 4'd0;
         tick_count_ff  <= 17'd0;
      end else if (step) begin
         active_ff      <= active_in;
         listening_ff   <= listening_in;
         got_data_ff    <= got_data_in;
         slave_index_ff <= slave_index_in;
         tick_count_ff  <= tick_count_in;
      end
   end

   a_listen_needs_active: assert property (@(posedge clock) disable iff (reset)
      listening_ff |-> active_ff) else $error("listening while idle");
   a_idle_no_data: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (!got_data_ff && tick_count_ff == 17'd0))
      else $error("idle with leftover slave state");
   a_idle_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (step && !active_ff && item.func == FUNC_TICK) |-> bundle.count == 2'd0)
      else $error("tick while idle produced results");

endmodule

`default_nettype wire

@@ sv/mpc_out.sv @@
// ----------------------------------------------------------------------------
// mpc_out
// Result sequencer: holds one event's bundle and hands its results one per
// cycle, while rsp_chan is not stalled, to the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_out (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire mpc_pkg::mpc_bundle_type bundle,
   output logic                         free,
   mpc_rsp_if.source                    rsp_chan
);
   import mpc_pkg::*;

   logic           b_valid_ff;
   mpc_bundle_type b_data_ff;
   logic [1:0]     b_idx_ff;
   logic           rsp_valid_ff;
   mpc_result_type rsp_data_ff;

   logic           out_open;
   logic           drain;
   logic           finishing;

   assign out_open  = !rsp_valid_ff || rsp_chan.ready;
   assign drain     = b_valid_ff && out_open;
   assign finishing = drain && (b_idx_ff == b_data_ff.count - 2'd1);
   assign free      = !b_valid_ff || finishing;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_idx_ff   <= 2'd0;
      end else if (load) begin
         b_valid_ff <= 1'b1;
         b_idx_ff   <= 2'd0;
      end else if (finishing) begin
         b_valid_ff <= 1'b0;
      end else if (drain) begin
         b_idx_ff <= b_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b_data_ff <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (drain) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         rsp_data_ff <= b_data_ff.entry[b_idx_ff];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_data_ff.result_kind;
   assign rsp_chan.slave_id     = rsp_data_ff.slave_id;
   assign rsp_chan.command_byte = rsp_data_ff.command_byte;
   assign rsp_chan.session      = rsp_data_ff.session;
   assign rsp_chan.counter      = rsp_data_ff.counter;
   assign rsp_chan.last         = rsp_data_ff.last;

   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_data_ff.count != 2'd0 && b_idx_ff < b_data_ff.count))
      else $error("bundle index out of range");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free) else $error("bundle overwritten before drained");
   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      finishing |=> rsp_data_ff.last) else $error("final result of item lacks last");

endmodule

`default_nettype wire

@@ tb/mpc_poll_checker.sv @@
// ----------------------------------------------------------------------------
// mpc_poll_checker
// Watches the event, result and csr ports of the poll collector, keeps its
// own copy of the polling state and settings, works out the results of each
// accepted event item and compares every accepted result, field by field,
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module mpc_poll_checker (
   input  logic        clock,
   input  logic        reset,
   mpc_req_if          req_mon,
   mpc_rsp_if          rsp_mon,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          mismatch_count,
   output int          awaited_count,
   output logic        collecting,
   output logic [3:0]  polled_slave
);
   timeunit 1ns;
   timeprecision 1ps;
   import mpc_pkg::*;

   localparam int PRINT_LIMIT = 50;

   mpc_cfg_type    cfg;
   logic           active;
   logic           listening;
   logic           got_data;
   logic [3:0]     slave_index;
   logic [16:0]    tick_count;
   mpc_result_type awaited_results [$];
   mpc_result_type staged [MAX_RESULTS];
   int             staged_n;

   assign collecting   = active;
   assign polled_slave = slave_index;

   task automatic stage(input mpc_kind_type kind, input logic [3:0] sid,
                        input logic [7:0] cmd, input logic [7:0] ses,
                        input logic [15:0] cnt);
      staged[staged_n] = '{kind, sid, cmd, ses, cnt, 1'b0};
      staged_n++;
   endtask

   // slave_total of 0 still polls one slave; never more than a 4-bit id reaches
   function automatic logic [4:0] slaves_in_use();
      logic [4:0] total;
      total = cfg.slave_total;
      if (total == 5'd0)
         total = 5'd1;
      if (total > SLAVE_CAP)
         total = SLAVE_CAP;
      return total;
   endfunction

   task automatic open_slave(input logic [3:0] idx);
      slave_index = idx;
      tick_count  = '0;
      got_data    = 1'b0;
      listening   = 1'b1;
   endtask

   task automatic close_slave();
      if (got_data)
         stage(KIND_DONE, slave_index, cfg.done_command, 8'h00, 16'h0000);
      if ({1'b0, slave_index} + 5'd1 >= slaves_in_use()) begin
         active     = 1'b0;
         listening  = 1'b0;
         got_data   = 1'b0;
         tick_count = '0;
         stage(KIND_FINISHED, 4'd0, 8'h00, 8'h00, 16'h0000);
      end else begin
         open_slave(slave_index + 4'd1);
         stage(KIND_REQUEST, slave_index, cfg.request_command, 8'h00, 16'h0000);
      end
   endtask

   task automatic predict_event(input mpc_item_type ev);
      staged_n = 0;
      case (ev.func)
         FUNC_START: begin
            active = 1'b1;
            open_slave(4'd0);
            stage(KIND_REQUEST, 4'd0, cfg.request_command, 8'h00, 16'h0000);
         end
         FUNC_TICK: begin
            if (active) begin
               if (tick_count != TICK_MAX)
                  tick_count++;
               if (tick_count > {1'b0, cfg.timeout_ticks})
                  close_slave();
            end
         end
         FUNC_FRAME: begin
            if (active && listening && ev.frame_length == FRAME_LEN &&
                ev.frame_start == cfg.start_marker &&
                ev.frame_slave == {4'h0, slave_index}) begin
               got_data = 1'b1;
               stage(KIND_RECORD, slave_index, 8'h00, ev.frame_session,
                     {ev.frame_count_high, ev.frame_count_low});
               // final wins when both codes are equal
               if (ev.frame_status == cfg.final_status_code)
                  close_slave();
               else if (ev.frame_status != cfg.continue_status_code)
                  listening = 1'b0;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < staged_n; i++) begin
         staged[i].last = (i == staged_n - 1);
         awaited_results.push_back(staged[i]);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] seen,
                                  input logic [15:0] wanted);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s: got %0h, expected %0h", $time, what, seen, wanted);
      mismatch_count++;
   endtask

   task automatic check_result();
      mpc_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("unexpected result, kind", 16'(rsp_mon.result_kind), 16'h0);
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_mon.result_kind !== want.result_kind)
         report_mismatch("result_kind", 16'(rsp_mon.result_kind), 16'(want.result_kind));
      if (rsp_mon.slave_id !== want.slave_id)
         report_mismatch("slave_id", 16'(rsp_mon.slave_id), 16'(want.slave_id));
      if (rsp_mon.command_byte !== want.command_byte)
         report_mismatch("command_byte", 16'(rsp_mon.command_byte),
                         16'(want.command_byte));
      if (rsp_mon.session !== want.session)
         report_mismatch("session", 16'(rsp_mon.session), 16'(want.session));
      if (rsp_mon.counter !== want.counter)
         report_mismatch("counter", rsp_mon.counter, want.counter);
      if (rsp_mon.last !== want.last)
         report_mismatch("last", 16'(rsp_mon.last), 16'(want.last));
   endtask

   task automatic apply_write();
      case (csr_index)
         CSR_START_MARKER:    cfg.start_marker         = csr_write_data[7:0];
         CSR_REQUEST_COMMAND: cfg.request_command      = csr_write_data[7:0];
         CSR_DONE_COMMAND:    cfg.done_command         = csr_write_data[7:0];
         CSR_FINAL_STATUS:    cfg.final_status_code    = csr_write_data[7:0];
         CSR_CONTINUE_STATUS: cfg.continue_status_code = csr_write_data[7:0];
         CSR_TIMEOUT_TICKS:   cfg.timeout_ticks        = csr_write_data;
         CSR_SLAVE_TOTAL:     cfg.slave_total          = csr_write_data[4:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{start_marker: 8'd170, request_command: 8'd1, done_command: 8'd2,
                 final_status_code: 8'd0, continue_status_code: 8'd1,
                 timeout_ticks: 16'd100, slave_total: 5'd16};
         active         = 1'b0;
         listening      = 1'b0;
         got_data       = 1'b0;
         slave_index    = 4'd0;
         tick_count     = '0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         // a result leaving now can only belong to an earlier item
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
         if (req_mon.valid && req_mon.ready)
            predict_event('{req_mon.func, req_mon.frame_length, req_mon.frame_start,
                            req_mon.frame_slave, req_mon.frame_session,
                            req_mon.frame_count_low, req_mon.frame_count_high,
                            req_mon.frame_status});
         if (csr_write_enable)
            apply_write();
      end
      awaited_count = awaited_results.size();
   end

endmodule

@@ tb/multidrop_poll_collector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// multidrop_poll_collector_unit_tb
// Drives start, tick and frame event items into the poll collector under a
// series of register settings and idle patterns; a side checker predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module multidrop_poll_collector_unit_tb ();
   timeunit 1ns;
   timeprecision 1ps;
   import mpc_pkg::*;

   localparam int         CYCLE_LIMIT   = 600_000;
   localparam int         HOLD_CYCLES   = 120;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         PHASE_COUNT   = 8;
   localparam int         PHASE_ITEMS   = 28;
   localparam int         LONG_TICKS    = 12;
   localparam logic [1:0] FUNC_UNUSED   = 2'd3;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [15:0] csr_write_data;

   mpc_req_if req_bus ();
   mpc_rsp_if rsp_bus ();

   int          mismatch_count;
   int          awaited_count;
   logic        collecting;
   logic [3:0]  polled_slave;

   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          hold_requests      = 0;
   int          holds_served       = 0;
   int          cycle_count        = 0;
   mpc_cfg_type settings_now;

   multidrop_poll_collector_unit i_dut (
      .clock,
      .reset,
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_write_enable,
      .csr_index,
      .csr_write_data
   );

   mpc_poll_checker i_poll_check (
      .clock,
      .reset,
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .csr_write_enable,
      .csr_index,
      .csr_write_data,
      .mismatch_count,
      .awaited_count,
      .collecting,
      .polled_slave
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic mpc_item_type bare_event(input logic [1:0] func);
      logic [63:0]  noise;
      mpc_item_type ev;
      noise = {$urandom(), $urandom()};
      ev = noise[$bits(mpc_item_type)-1:0];
      ev.func = func;
      return ev;
   endfunction

   function automatic mpc_item_type frame_event(input logic [7:0] start_byte,
                                                input logic [7:0] slave_byte,
                                                input logic [7:0] ses,
                                                input logic [7:0] lo,
                                                input logic [7:0] hi,
                                                input logic [7:0] status);
      mpc_item_type ev;
      ev.func             = FUNC_FRAME;
      ev.frame_length     = FRAME_LEN;
      ev.frame_start      = start_byte;
      ev.frame_slave      = slave_byte;
      ev.frame_session    = ses;
      ev.frame_count_low  = lo;
      ev.frame_count_high = hi;
      ev.frame_status     = status;
      return ev;
   endfunction

   // mostly well-formed frames for the slave being polled, with ticks,
   // restarts, corrupted frames and plain noise mixed in
   function automatic mpc_item_type random_event();
      mpc_item_type ev;
      int           pick;
      int           tone;
      logic [7:0]   status;
      ev = bare_event(FUNC_UNUSED);
      pick = $urandom_range(99);
      if (!collecting) begin
         if (pick < 55)
            ev.func = FUNC_START;
         else if (pick < 75)
            ev.func = FUNC_TICK;
         else
            ev.func = 2'($urandom_range(3));
      end else if (pick < 50 || (pick >= 72 && pick < 84)) begin
         tone = $urandom_range(99);
         if (tone < 35)
            status = settings_now.continue_status_code;
         else if (tone < 70)
            status = settings_now.final_status_code;
         else
            status = 8'($urandom);
         ev = frame_event(settings_now.start_marker, {4'h0, polled_slave}, 8'($urandom),
                          8'($urandom), 8'($urandom), status);
         if (pick >= 72) begin
            case ($urandom_range(2))
               0:       ev.frame_length ^= 8'($urandom_range(1, 255));
               1:       ev.frame_start  ^= 8'($urandom_range(1, 255));
               default: ev.frame_slave  ^= 8'($urandom_range(1, 255));
            endcase
         end
      end else if (pick < 72) begin
         ev.func = FUNC_TICK;
      end else if (pick < 88) begin
         ev.func = FUNC_START;
      end else if (pick < 92) begin
         ev.func = FUNC_UNUSED;
      end else begin
         ev.func = 2'($urandom_range(3));
      end
      return ev;
   endfunction

   function automatic mpc_cfg_type random_settings(input int phase);
      mpc_cfg_type s;
      case (phase)
         0: s = '0;
         1: s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 16'd2, 5'd31};
         default: begin
            s.start_marker         = 8'($urandom);
            s.request_command      = 8'($urandom);
            s.done_command         = 8'($urandom);
            s.final_status_code    = 8'($urandom);
            s.continue_status_code = ($urandom_range(4) == 0) ? s.final_status_code
                                                               : 8'($urandom);
            s.timeout_ticks        = 16'($urandom_range(0, 5));
            s.slave_total          = ($urandom_range(3) == 0) ? 5'($urandom_range(16, 31))
                                                              : 5'($urandom_range(1, 5));
         end
      endcase
      return s;
   endfunction

   task automatic place(input mpc_item_type ev);
      req_bus.func             = ev.func;
      req_bus.frame_length     = ev.frame_length;
      req_bus.frame_start      = ev.frame_start;
      req_bus.frame_slave      = ev.frame_slave;
      req_bus.frame_session    = ev.frame_session;
      req_bus.frame_count_low  = ev.frame_count_low;
      req_bus.frame_count_high = ev.frame_count_high;
      req_bus.frame_status     = ev.frame_status;
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input mpc_item_type ev);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      place(ev);
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // no item in flight: all results back, then room for a resultless item
   task automatic drain();
      req_bus.valid = 1'b0;
      while (awaited_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input mpc_cfg_type s);
      write_reg(CSR_START_MARKER, 16'(s.start_marker));
      write_reg(CSR_REQUEST_COMMAND, 16'(s.request_command));
      write_reg(CSR_DONE_COMMAND, 16'(s.done_command));
      write_reg(CSR_FINAL_STATUS, 16'(s.final_status_code));
      write_reg(CSR_CONTINUE_STATUS, 16'(s.continue_status_code));
      write_reg(CSR_TIMEOUT_TICKS, s.timeout_ticks);
      write_reg(CSR_SLAVE_TOTAL, 16'(s.slave_total));
      csr_write_enable = 1'b0;
      settings_now     = s;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 69;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 69;
         end
         default: begin
            sender_idle_pct    = 18;
            receiver_stall_pct = 18;
         end
      endcase
   endtask

   initial begin
      mpc_item_type ev;
      int           counted;
      bit           paused;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_START_MARKER;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      place('0);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle block ignores everything but a start
      offer(bare_event(FUNC_TICK));
      offer(frame_event(8'hAA, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00));
      offer(bare_event(FUNC_UNUSED));
      // register defaults
      offer(bare_event(FUNC_START));
      offer(frame_event(8'hAA, 8'h00, 8'h5A, 8'h34, 8'h12, 8'h00));

      drain();
      apply_settings('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1, 5'd2});
      offer(bare_event(FUNC_START));
      offer(frame_event(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      ev = frame_event(8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'hFF);
      ev.frame_length = 8'd5;
      offer(ev);
      offer(frame_event(8'h7F, 8'h00, 8'h11, 8'h22, 8'h33, 8'hFF));
      offer(frame_event(8'hFF, 8'h01, 8'h11, 8'h22, 8'h33, 8'hFF));
      offer(frame_event(8'hFF, 8'h10, 8'h11, 8'h22, 8'h33, 8'hFF));
      // unknown status: record, then deaf until timeout
      offer(frame_event(8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'h55));
      offer(frame_event(8'hFF, 8'h00, 8'h44, 8'h55, 8'h66, 8'h00));
      offer(bare_event(FUNC_TICK));
      offer(bare_event(FUNC_TICK));
      // restart while a collection runs
      offer(bare_event(FUNC_START));
      offer(frame_event(8'hFF, 8'h00, 8'h80, 8'h01, 8'h80, 8'h00));
      offer(frame_event(8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
      // silent slaves: timeouts without data
      offer(bare_event(FUNC_START));
      repeat (4) offer(bare_event(FUNC_TICK));

      // equal final and continue codes, zero slave count, zero timeout
      drain();
      apply_settings('{8'h00, 8'hFF, 8'h00, 8'h33, 8'h33, 16'd0, 5'd0});
      offer(bare_event(FUNC_START));
      offer(frame_event(8'h00, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h33));
      offer(bare_event(FUNC_START));
      offer(bare_event(FUNC_TICK));

      // timeout runs out after data came in
      drain();
      apply_settings('{8'hAA, 8'h01, 8'h02, 8'h00, 8'h01, 16'(LONG_TICKS - 1), 5'd1});
      offer(bare_event(FUNC_START));
      offer(frame_event(8'hAA, 8'h00, 8'h12, 8'h34, 8'h56, 8'h01));
      repeat (LONG_TICKS) offer(bare_event(FUNC_TICK));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         apply_settings(random_settings(phase));
         set_idling(phase % 4);
         if (phase == 4)
            hold_requests++;
         counted = 0;
         paused  = 1'b0;
         while (counted < PHASE_ITEMS) begin
            if (phase == 5 && !paused && counted == PHASE_ITEMS / 2) begin
               paused = 1'b1;
               drain();
            end
            ev = random_event();
            if (ev.func == FUNC_START || (collecting && ev.func != FUNC_UNUSED))
               counted++;
            offer(ev);
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
